/* hdl/wrp_pkg.sv */
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants of the WAV stream parser: parse phases, status
// codes, tags, the result word layout and the result queue geometry.
// ----------------------------------------------------------------------------
package wrp_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int MIN_LEN = 44;
    localparam logic [7:0] SAMPLE_BIAS = 8'd128;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic ITEM_SAMPLE  = 1'b0;
    localparam logic ITEM_SUMMARY = 1'b1;

    typedef enum logic [6:0] {
        PH_RIFF   = 7'b000_0001,
        PH_BADTAG = 7'b000_0010,
        PH_CHDR   = 7'b000_0100,
        PH_OTHER  = 7'b000_1000,
        PH_FMT    = 7'b001_0000,
        PH_DATA   = 7'b010_0000,
        PH_PAD    = 7'b100_0000
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_BAD_TAG      = 3'd2,
        ST_NOT_PCM      = 3'd3,
        ST_NO_DATA      = 3'd4,
        ST_BAD_RATE     = 3'd5,
        ST_BAD_CHANNELS = 3'd6,
        ST_BAD_BITS     = 3'd7
    } status_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        status_t            status;
        logic [30:0]        rate;
        logic [1:0]         channels;
        logic [30:0]        frames;
        logic               run_end;
    } result_t;

    // Up to two result words per input byte; the first is always delivered first.
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first_res;
        result_t second_res;
    } push_ctl_t;

endpackage

/* hdl/wav_riff_stream_parser.sv */
// ----------------------------------------------------------------------------
// wav_riff_stream_parser
// Byte-serial RIFF/WAVE PCM parser: checks the file tags, walks the chunks,
// streams PCM samples as signed 16-bit words and ends each file with a
// summary word.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one byte of the file per word, with last_byte set
// on the final byte. The output channel returns sample words (item_kind 0)
// from the data chunk and one summary word (item_kind 1) after the final
// byte; run_end marks the last word caused by a byte.
// A byte is taken into an input register, parsed there and its words are
// written to a four-entry result queue. The first result is written from the
// input register into the queue once the queue has room, and is offered on
// the output from there. One byte is accepted per cycle while the queue has
// room; the rate is set by the result queue, which must have room for two words
// before the input register can retire a byte, so a byte that yields a sample
// and the summary puts two words on the output side.
// Reset clears the parse state and empties the queue; the parser also
// returns to its reset state after every final byte. When the receiver
// stalls, the queue fills and byte_ready drops while three or more words
// wait and a byte is held in the input register.
// ----------------------------------------------------------------------------
module wav_riff_stream_parser
    import wrp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               item_kind,
    output logic signed [15:0] sample_value,
    output logic [2:0]         parse_status,
    output logic [30:0]        sample_rate,
    output logic [1:0]         channel_count,
    output logic [30:0]        frame_count,
    output logic               run_end
);

    push_ctl_t push;
    logic      space_ok;
    result_t   head;

    wrp_parse_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .space_ok   (space_ok),
        .push       (push)
    );

    wrp_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .space_ok     (space_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .head         (head)
    );

    assign item_kind     = head.kind;
    assign sample_value  = head.sample;
    assign parse_status  = head.status;
    assign sample_rate   = head.rate;
    assign channel_count = head.channels;
    assign frame_count   = head.frames;
    assign run_end       = head.run_end;

endmodule

/* hdl/wrp_parse_core.sv */
// ----------------------------------------------------------------------------
// wrp_parse_core
// Input register and the parse state of the WAV stream parser. Each byte in
// the input register updates the chunk walker and yields up to two results.
// ----------------------------------------------------------------------------
module wrp_parse_core
    import wrp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  logic [7:0] data_byte,
    input  logic      last_byte,
    input  logic      space_ok,
    output push_ctl_t push
);

    logic                   stage_valid_reg;
    logic [7:0]             stage_byte_reg;
    logic                   stage_last_reg;
    logic                   advance;
    logic                   accept;

    phase_t                 phase_reg, phase_step, phase_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_step, total_next;
    logic [63:0]            header_reg, header_step, header_next;
    logic [31:0]            remain_reg, remain_step, remain_next;
    logic [4:0]             offset_reg, offset_step, offset_next;
    logic                   pad_reg, pad_step, pad_next;
    logic [15:0]            code_reg, code_step, code_next;
    logic [15:0]            chan_reg, chan_step, chan_next;
    logic [31:0]            rate_reg, rate_step, rate_next;
    logic [15:0]            bits_reg, bits_step, bits_next;
    logic                   seen_reg, seen_step, seen_next;
    logic [COUNT_WIDTH-1:0] dlen_reg, dlen_step, dlen_next;
    logic [8:0]             hold_reg, hold_step, hold_next;

    logic                   body;
    logic                   sample_hit;
    logic [15:0]            sample_word;
    logic [7:0]             x;
    logic [2:0]             riff_lane;
    logic [63:0]            chdr_word;
    logic [31:0]            chunk_size;
    logic [31:0]            chunk_tag;

    status_t                status;
    logic [1:0]             frame_shift;
    logic [31:0]            frames_wide;
    result_t                sample_res;
    result_t                summary_res;

    assign x          = stage_byte_reg;
    assign advance    = stage_valid_reg & space_ok;
    assign byte_ready = ~stage_valid_reg | space_ok;
    assign accept     = byte_valid & byte_ready;
    assign riff_lane  = {offset_reg[3], offset_reg[1:0]};
    // Chunk header with the current byte merged in.
    assign chdr_word  = header_reg | (64'(x) << {offset_reg[2:0], 3'b000});
    assign chunk_tag  = chdr_word[31:0];
    assign chunk_size = chdr_word[63:32];

    always_comb
    begin
        phase_step  = phase_reg;
        header_step = header_reg;
        remain_step = remain_reg;
        offset_step = offset_reg;
        pad_step    = pad_reg;
        code_step   = code_reg;
        chan_step   = chan_reg;
        rate_step   = rate_reg;
        bits_step   = bits_reg;
        seen_step   = seen_reg;
        dlen_step   = dlen_reg;
        hold_step   = hold_reg;
        body        = 1'b0;
        sample_hit  = 1'b0;
        sample_word = '0;
        total_step  = (total_reg != '1) ? total_reg + 1'b1 : total_reg;

        unique case (phase_reg)
            PH_RIFF:
            begin
                // Tag bytes sit at offsets 0..3 and 8..11; the file size is skipped.
                if (offset_reg < 5'd4 || (offset_reg >= 5'd8 && offset_reg < 5'd12))
                begin
                    header_step = header_reg | (64'(x) << {riff_lane, 3'b000});
                end
                offset_step = offset_reg + 5'd1;
                if (offset_reg >= 5'd11)
                begin
                    phase_step  = (header_step[31:0] == TAG_RIFF &&
                                   header_step[63:32] == TAG_WAVE) ? PH_CHDR : PH_BADTAG;
                    header_step = '0;
                    offset_step = '0;
                end
            end
            PH_BADTAG:
            begin
                phase_step = PH_BADTAG;
            end
            PH_CHDR:
            begin
                header_step = chdr_word;
                offset_step = offset_reg + 5'd1;
                if (offset_reg >= 5'd7)
                begin
                    header_step = '0;
                    offset_step = '0;
                    // A negative size runs to the end of the file.
                    if (chunk_size[31])
                    begin
                        remain_step = '1;
                        pad_step    = 1'b0;
                    end
                    else
                    begin
                        remain_step = chunk_size;
                        pad_step    = chunk_size[0];
                    end
                    if (chunk_tag == TAG_FMT)
                    begin
                        phase_step = PH_FMT;
                    end
                    else if (chunk_tag == TAG_DATA)
                    begin
                        phase_step = PH_DATA;
                        seen_step  = 1'b1;
                        dlen_step  = '0;
                        hold_step  = '0;
                    end
                    else
                    begin
                        phase_step = PH_OTHER;
                    end
                    if (remain_step == '0)
                    begin
                        phase_step = PH_CHDR;
                    end
                end
            end
            PH_OTHER:
            begin
                body = 1'b1;
            end
            PH_FMT:
            begin
                if (offset_reg < 5'd8)
                begin
                    header_step = header_reg | (64'(x) << {offset_reg[2:0], 3'b000});
                end
                else if (offset_reg == 5'd14)
                begin
                    hold_step = {1'b0, x};
                end
                else if (offset_reg == 5'd15)
                begin
                    code_step = header_reg[15:0];
                    chan_step = header_reg[31:16];
                    rate_step = header_reg[63:32];
                    bits_step = {x, hold_reg[7:0]};
                    hold_step = '0;
                end
                if (offset_reg < 5'd16)
                begin
                    offset_step = offset_reg + 5'd1;
                end
                body = 1'b1;
            end
            PH_DATA:
            begin
                if (dlen_reg != '1)
                begin
                    dlen_step = dlen_reg + 1'b1;
                end
                if (bits_reg == 16'd8)
                begin
                    sample_hit  = 1'b1;
                    sample_word = {x ^ SAMPLE_BIAS, 8'h00};
                end
                else if (bits_reg == 16'd16)
                begin
                    if (hold_reg[8])
                    begin
                        sample_hit  = 1'b1;
                        sample_word = {x, hold_reg[7:0]};
                        hold_step   = '0;
                    end
                    else
                    begin
                        hold_step = {1'b1, x};
                    end
                end
                body = 1'b1;
            end
            default:
            begin
                phase_step  = PH_CHDR;
                offset_step = '0;
                header_step = '0;
            end
        endcase

        // Count down the chunk body; an all-ones count never runs out.
        if (body && remain_reg != '1)
        begin
            remain_step = remain_reg - 32'd1;
            if (remain_reg == 32'd1)
            begin
                phase_step = pad_reg ? PH_PAD : PH_CHDR;
            end
        end

        if (phase_reg == PH_FMT && phase_step != PH_FMT)
        begin
            header_step = '0;
            offset_step = '0;
            hold_step   = '0;
        end
    end

    // File summary, checked in priority order on the state after this byte.
    always_comb
    begin
        if (total_step < COUNT_WIDTH'(MIN_LEN))
        begin
            status = ST_SHORT;
        end
        else if (phase_step == PH_BADTAG || phase_step == PH_RIFF)
        begin
            status = ST_BAD_TAG;
        end
        else if (code_step != 16'd1)
        begin
            status = ST_NOT_PCM;
        end
        else if (!seen_step)
        begin
            status = ST_NO_DATA;
        end
        else if (rate_step == 32'd0 || rate_step[31])
        begin
            status = ST_BAD_RATE;
        end
        else if (chan_step != 16'd1 && chan_step != 16'd2)
        begin
            status = ST_BAD_CHANNELS;
        end
        else if (bits_step != 16'd8 && bits_step != 16'd16)
        begin
            status = ST_BAD_BITS;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // Bytes per frame is 1, 2 or 4 once the checks pass, so the divide is a shift.
    assign frame_shift = {1'b0, bits_step == 16'd16} + {1'b0, chan_step == 16'd2};
    assign frames_wide = 32'(dlen_step) >> frame_shift;

    always_comb
    begin
        sample_res          = '0;
        sample_res.kind     = ITEM_SAMPLE;
        sample_res.sample   = sample_word;
        sample_res.status   = ST_OK;
        sample_res.run_end  = ~stage_last_reg;

        summary_res         = '0;
        summary_res.kind    = ITEM_SUMMARY;
        summary_res.status  = status;
        summary_res.run_end = 1'b1;
        if (status == ST_OK)
        begin
            summary_res.rate     = rate_step[30:0];
            summary_res.channels = chan_step[1:0];
            summary_res.frames   = frames_wide[31] ? 31'h7FFF_FFFF : frames_wide[30:0];
        end
    end

    always_comb
    begin
        push.first_valid  = advance & (sample_hit | stage_last_reg);
        push.second_valid = advance & sample_hit & stage_last_reg;
        push.first_res    = sample_hit ? sample_res : summary_res;
        push.second_res   = summary_res;
    end

    // The final byte returns the parser to its reset state for the next file.
    always_comb
    begin
        if (stage_last_reg)
        begin
            phase_next  = PH_RIFF;
            total_next  = '0;
            header_next = '0;
            remain_next = '0;
            offset_next = '0;
            pad_next    = 1'b0;
            code_next   = '0;
            chan_next   = '0;
            rate_next   = '0;
            bits_next   = '0;
            seen_next   = 1'b0;
            dlen_next   = '0;
            hold_next   = '0;
        end
        else
        begin
            phase_next  = phase_step;
            total_next  = total_step;
            header_next = header_step;
            remain_next = remain_step;
            offset_next = offset_step;
            pad_next    = pad_step;
            code_next   = code_step;
            chan_next   = chan_step;
            rate_next   = rate_step;
            bits_next   = bits_step;
            seen_next   = seen_step;
            dlen_next   = dlen_step;
            hold_next   = hold_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            phase_reg       <= PH_RIFF;
            total_reg       <= '0;
            header_reg      <= '0;
            remain_reg      <= '0;
            offset_reg      <= '0;
            pad_reg         <= 1'b0;
            code_reg        <= '0;
            chan_reg        <= '0;
            rate_reg        <= '0;
            bits_reg        <= '0;
            seen_reg        <= 1'b0;
            dlen_reg        <= '0;
            hold_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                phase_reg  <= phase_next;
                total_reg  <= total_next;
                header_reg <= header_next;
                remain_reg <= remain_next;
                offset_reg <= offset_next;
                pad_reg    <= pad_next;
                code_reg   <= code_next;
                chan_reg   <= chan_next;
                rate_reg   <= rate_next;
                bits_reg   <= bits_next;
                seen_reg   <= seen_next;
                dlen_reg   <= dlen_next;
                hold_reg   <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= data_byte;
            stage_last_reg <= last_byte;
        end
    end

endmodule

/* hdl/wrp_result_queue.sv */
// ----------------------------------------------------------------------------
// wrp_result_queue
// Small result queue of the WAV stream parser. Takes up to two words a cycle
// from the parser and hands them out one at a time.
// ----------------------------------------------------------------------------
module wrp_result_queue
    import wrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_ctl_t push,
    output logic      space_ok,
    output logic      result_valid,
    input  logic      result_ready,
    output result_t   head
);

    result_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                pop;
    logic [QUEUE_AW:0]   push_count;

    assign result_valid = (count_reg != '0);
    assign pop          = result_valid & result_ready;
    assign head         = entry_reg[rd_ptr_reg];
    // Room for two more words guarantees any byte can be retired.
    assign space_ok     = (count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

    assign push_count   = (QUEUE_AW + 1)'(push.first_valid) +
                          (QUEUE_AW + 1)'(push.second_valid);
    assign wr_ptr_next  = wr_ptr_reg + push_count[QUEUE_AW-1:0];
    assign rd_ptr_next  = rd_ptr_reg + QUEUE_AW'(pop);
    assign count_next   = count_reg + push_count - (QUEUE_AW + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            entry_reg[wr_ptr_reg] <= push.first_res;
        end
        if (push.second_valid)
        begin
            entry_reg[wr_ptr_reg + QUEUE_AW'(1)] <= push.second_res;
        end
    end

endmodule
